### src/fbde_pkg.sv
// Shared constants, command codes and the queued command format of the framebuffer draw engine.
package fbde_pkg;

  // Panel geometry. Each stored byte is a vertical strip of eight pixels.
  localparam int PANEL_COLUMNS  = 128;
  localparam int PANEL_MAX_ROWS = 64;

  localparam int STORE_PAGES = (PANEL_MAX_ROWS + 7) / 8;
  localparam int STORE_DEPTH = PANEL_COLUMNS * STORE_PAGES;

  localparam int COL_W  = $clog2(PANEL_COLUMNS);
  localparam int PAGE_W = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // Command queue between the decoder and the executor.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Host operation codes.
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_PIXEL = 3'd1;
  localparam logic [2:0] OP_RECT  = 3'd2;
  localparam logic [2:0] OP_BLIT  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // What the executor has to do with a queued command.
  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_DRAW  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_kind_t;

  // A draw command covers a clipped block of bytes: columns col_first..col_last and
  // pages page_first..page_last. lo_bit is the first row bit in the first page and
  // hi_bit the last row bit in the last page. A blit takes its column pixels from
  // image (bit 7 at col_first); otherwise every covered pixel is set.
  typedef struct packed {
    cmd_kind_t          kind;
    logic               blit;
    logic [COL_W-1:0]   col_first;
    logic [COL_W-1:0]   col_last;
    logic [PAGE_W-1:0]  page_first;
    logic [PAGE_W-1:0]  page_last;
    logic [2:0]         lo_bit;
    logic [2:0]         hi_bit;
    logic [7:0]         image;
    logic [ADDR_W-1:0]  read_address;
    logic               read_zero;
  } cmd_t;

endpackage

### src/fbde_front.sv
// Command decoder: holds the panel height register and turns host words into clipped commands.
module fbde_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic           cfg_data,
  input  logic [2:0]     op,
  input  logic [7:0]     x,
  input  logic [7:0]     y,
  input  logic           pixel_value,
  input  logic [7:0]     rect_width,
  input  logic [7:0]     rect_height,
  input  logic [7:0]     image_byte,
  input  logic [3:0]     valid_bits,
  input  logic [9:0]     read_address,
  output fbde_pkg::cmd_t cmd
);
  import fbde_pkg::*;

  logic       tall_panel;
  logic [8:0] active_rows;
  logic       x_on;
  logic       y_on;
  logic [8:0] rect_x_sum;
  logic [8:0] rect_x_end;
  logic [8:0] rect_y_sum;
  logic [8:0] rect_y_end;
  logic [8:0] rect_last_row;
  logic [8:0] rect_last_col;
  logic [3:0] blit_count;
  logic [8:0] blit_x_sum;
  logic [8:0] blit_x_end;
  logic [8:0] blit_last_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      tall_panel <= 1'b1;
    end else if (cfg_write) begin
      tall_panel <= cfg_data;
    end
  end

  always_comb begin
    active_rows = tall_panel ? 9'(PANEL_MAX_ROWS) : 9'(PANEL_MAX_ROWS / 2);
    x_on = {1'b0, x} < 9'(PANEL_COLUMNS);
    y_on = {1'b0, y} < active_rows;

    rect_x_sum = {1'b0, x} + {1'b0, rect_width};
    rect_x_end = (rect_x_sum > 9'(PANEL_COLUMNS)) ? 9'(PANEL_COLUMNS) : rect_x_sum;
    rect_y_sum = {1'b0, y} + {1'b0, rect_height};
    rect_y_end = (rect_y_sum > active_rows) ? active_rows : rect_y_sum;
    rect_last_col = rect_x_end - 9'd1;
    rect_last_row = rect_y_end - 9'd1;

    blit_count = (valid_bits > 4'd8) ? 4'd8 : valid_bits;
    blit_x_sum = {1'b0, x} + {5'd0, blit_count};
    blit_x_end = (blit_x_sum > 9'(PANEL_COLUMNS)) ? 9'(PANEL_COLUMNS) : blit_x_sum;
    blit_last_col = blit_x_end - 9'd1;

    cmd = '0;
    cmd.kind = CMD_NOP;
    cmd.col_first = COL_W'(x);
    cmd.page_first = PAGE_W'(y >> 3);
    cmd.page_last = PAGE_W'(y >> 3);
    cmd.lo_bit = y[2:0];
    cmd.hi_bit = y[2:0];
    cmd.read_address = ADDR_W'(read_address);
    cmd.read_zero = int'(read_address) >= STORE_DEPTH;

    unique case (op)
      OP_CLEAR: begin
        cmd.kind = CMD_CLEAR;
      end
      OP_PIXEL: begin
        // A single pixel is a one-column blit whose leading image bit is the value.
        if (x_on && y_on) begin
          cmd.kind = CMD_DRAW;
        end
        cmd.blit = 1'b1;
        cmd.col_last = COL_W'(x);
        cmd.image = {pixel_value, 7'd0};
      end
      OP_RECT: begin
        if (({1'b0, x} < rect_x_end) && ({1'b0, y} < rect_y_end)) begin
          cmd.kind = CMD_DRAW;
        end
        cmd.col_last = COL_W'(rect_last_col);
        cmd.page_last = PAGE_W'(rect_last_row >> 3);
        cmd.hi_bit = rect_last_row[2:0];
      end
      OP_BLIT: begin
        if (x_on && y_on && (blit_count != 4'd0)) begin
          cmd.kind = CMD_DRAW;
        end
        cmd.blit = 1'b1;
        cmd.col_last = COL_W'(blit_last_col);
        cmd.image = image_byte;
      end
      OP_READ: begin
        cmd.kind = CMD_READ;
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

endmodule

### src/fbde_cmd_queue.sv
// Short command queue that decouples the decoder from the executor.
module fbde_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fbde_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output fbde_pkg::cmd_t head_cmd,
  output logic           empty
);
  import fbde_pkg::*;

  cmd_t                  slots [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full     = count == CMDQ_CNT_W'(CMDQ_DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : CMDQ_PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : CMDQ_PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CMDQ_CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CMDQ_CNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

### src/fbde_back.sv
// Command executor: owns the frame store, runs clears, byte read-modify-writes and reads.
module fbde_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_empty,
  input  fbde_pkg::cmd_t head_cmd,
  output logic           cmd_pop,
  output logic           init_busy,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     read_data,
  output logic           was_read
);
  import fbde_pkg::*;

  typedef enum logic [4:0] {
    S_SWEEP = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WR    = 5'b00100,
    S_RDATA = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [PAGE_W-1:0] pg,
                                                  input logic [COL_W-1:0]  cl);
    byte_addr = ADDR_W'(int'(pg) * PANEL_COLUMNS + int'(cl));
  endfunction

  logic [7:0]        frame_store [STORE_DEPTH];
  logic [7:0]        rdata;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] sweep_addr;
  logic              sweep_last;
  logic              sweep_reply;
  cmd_t              cur;
  logic [COL_W-1:0]  col;
  logic [PAGE_W-1:0] page;
  logic [COL_W-1:0]  col_step;
  logic [PAGE_W-1:0] page_step;
  logic              last_page;
  logic              draw_last;
  logic [2:0]        lo;
  logic [2:0]        hi;
  logic [7:0]        mask;
  logic [2:0]        blit_idx;
  logic [7:0]        fill;
  logic [7:0]        new_byte;

  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [ADDR_W-1:0] rd_addr;

  logic              fin_valid;
  logic [7:0]        fin_data;
  logic              fin_read;
  logic              res_free;
  logic              res_valid;
  logic [7:0]        pend_data;
  logic              pend_read;

  assign sweep_last = sweep_addr == ADDR_W'(STORE_DEPTH - 1);
  assign init_busy  = (state == S_SWEEP) && !sweep_reply;
  assign res_free   = !res_valid || pop;
  assign empty      = !res_valid;

  // Byte walk: pages inside, columns outside. Every byte is visited once, so the read
  // of the next byte can overlap the write of the current one.
  always_comb begin
    last_page = page == cur.page_last;
    draw_last = last_page && (col == cur.col_last);
    page_step = last_page ? cur.page_first : PAGE_W'(page + 1'b1);
    col_step  = last_page ? COL_W'(col + 1'b1) : col;

    lo   = (page == cur.page_first) ? cur.lo_bit : 3'd0;
    hi   = last_page ? cur.hi_bit : 3'd7;
    mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
    blit_idx = 3'(col - cur.col_first);
    fill = cur.blit ? {8{cur.image[3'd7 - blit_idx]}} : 8'hFF;
    new_byte = (rdata & ~mask) | (fill & mask);

    mem_we  = (state == S_SWEEP) || (state == S_WR);
    wr_addr = (state == S_SWEEP) ? sweep_addr : byte_addr(page, col);
    wr_data = (state == S_SWEEP) ? 8'h00 : new_byte;

    rd_addr = byte_addr(page_step, col_step);
    if (state == S_IDLE) begin
      rd_addr = (head_cmd.kind == CMD_READ) ? head_cmd.read_address
                                            : byte_addr(head_cmd.page_first, head_cmd.col_first);
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    fin_valid  = 1'b0;
    fin_data   = 8'h00;
    fin_read   = 1'b0;
    unique case (state)
      S_SWEEP: begin
        if (sweep_last) begin
          fin_valid  = sweep_reply;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          unique case (head_cmd.kind)
            CMD_CLEAR: begin
              state_next = S_SWEEP;
            end
            CMD_DRAW: begin
              state_next = S_WR;
            end
            CMD_READ: begin
              if (head_cmd.read_zero) begin
                fin_valid = 1'b1;
                fin_read  = 1'b1;
              end else begin
                state_next = S_RDATA;
              end
            end
            default: begin
              fin_valid = 1'b1;
            end
          endcase
        end
      end
      S_WR: begin
        fin_valid = draw_last;
      end
      S_RDATA: begin
        fin_valid = 1'b1;
        fin_read  = 1'b1;
        fin_data  = rdata;
      end
      S_DONE: begin
        fin_valid = 1'b1;
        fin_read  = pend_read;
        fin_data  = pend_data;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin_valid) begin
      state_next = res_free ? S_IDLE : S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_addr  <= '0;
      sweep_reply <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SWEEP) begin
        sweep_addr <= sweep_last ? '0 : ADDR_W'(sweep_addr + 1'b1);
        if (sweep_last) begin
          sweep_reply <= 1'b0;
        end
      end
      if (cmd_pop && (head_cmd.kind == CMD_CLEAR)) begin
        sweep_reply <= 1'b1;
      end
      if (fin_valid && res_free) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur  <= head_cmd;
      col  <= head_cmd.col_first;
      page <= head_cmd.page_first;
    end else if ((state == S_WR) && !draw_last) begin
      col  <= col_step;
      page <= page_step;
    end
    if (fin_valid && !res_free) begin
      pend_data <= fin_data;
      pend_read <= fin_read;
    end
    if (fin_valid && res_free) begin
      read_data <= fin_data;
      was_read  <= fin_read;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[wr_addr] <= wr_data;
    end
    rdata <= frame_store[rd_addr];
  end

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (col >= cur.col_first) && (col <= cur.col_last) &&
                        (page >= cur.page_first) && (page <= cur.page_last))
    else $error("byte walk left the clipped command area");

  a_stall_parks: assert property (@(posedge clk) disable iff (rst)
    (fin_valid && !res_free) |=> (state == S_DONE) && res_valid)
    else $error("finished word not parked while the result register is full");

  a_init_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) && sweep_last |=> (state == S_IDLE) || (state == S_DONE))
    else $error("clearing sweep did not end after the last address");

  a_no_result_from_init: assert property (@(posedge clk) disable iff (rst)
    init_busy && !res_valid |=> !res_valid)
    else $error("a result word appeared during the reset sweep");

endmodule

### src/page_framebuffer_draw_engine.sv
// Top level of the page-organized 1 bpp framebuffer draw engine.
// A word's result is registered as the executor ends it: a pixel or read once its byte is
// read, a blit or rect once its clipped bytes are walked, a clear once the store is
// swept, an off-store read or a word that draws nothing once taken. It pops words only
// while idle; it issues the first byte read, then touches one stored byte a cycle through
// the single write port of the store, and a result still waiting to be popped stalls it.
// Reset: synchronous; the height register goes to tall, full stays high for the sweep.
module page_framebuffer_draw_engine (
  input  logic       clk,
  input  logic       rst,

  // Command words.
  input  logic       push,
  output logic       full,
  input  logic [2:0] op,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic       pixel_value,
  input  logic [7:0] rect_width,
  input  logic [7:0] rect_height,
  input  logic [7:0] image_byte,
  input  logic [3:0] valid_bits,
  input  logic [9:0] read_address,

  // Result words, one per command word.
  output logic       empty,
  input  logic       pop,
  output logic [7:0] read_data,
  output logic       was_read,

  // Panel height register: 1 clips to the full height, 0 to half of it.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import fbde_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic init_busy;

  // Always writable and unchecked: software must write it only while the engine is idle.
  assign cfg_ready = 1'b1;

  // The queue already blocks input while both its slots are taken; the reset sweep
  // also blocks it so that no word is taken before the store is clean. The sweep zeroes
  // the 1024-byte store one byte a cycle.
  assign full = q_full || init_busy;

  // The decoder clips every command against the panel and the current height, so the
  // executor only ever walks bytes it has to touch.
  fbde_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid),
    .cfg_data     (cfg_data),
    .op           (op),
    .x            (x),
    .y            (y),
    .pixel_value  (pixel_value),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .image_byte   (image_byte),
    .valid_bits   (valid_bits),
    .read_address (read_address),
    .cmd          (front_cmd)
  );

  // Two-entry queue so a new word can be taken while the executor is busy or its
  // result register waits to be popped.
  fbde_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push && !full),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  // The executor walks the store a byte a cycle and holds the result register.
  fbde_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (q_empty),
    .head_cmd  (head_cmd),
    .cmd_pop   (q_pop),
    .init_busy (init_busy),
    .pop       (pop),
    .empty     (empty),
    .read_data (read_data),
    .was_read  (was_read)
  );

endmodule

### bench/fb_draw_checker.sv
// Result predictor and comparator for the page framebuffer draw engine.
`timescale 1ns / 100ps
module fb_draw_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [2:0] op,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic       pixel_value,
  input  logic [7:0] rect_width,
  input  logic [7:0] rect_height,
  input  logic [7:0] image_byte,
  input  logic [3:0] valid_bits,
  input  logic [9:0] read_address,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] read_data,
  input  logic       was_read,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_data,
  output int         outstanding,
  output int         errors
);
  import fbde_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       was_rd;
  } reply_t;

  logic [7:0] pixel_bytes [STORE_DEPTH];
  bit         tall;
  reply_t     replies [$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  function automatic void wipe_store();
    for (int k = 0; k < STORE_DEPTH; k++) pixel_bytes[k] = 8'h00;
  endfunction

  function automatic int unsigned rows_now();
    return tall ? PANEL_MAX_ROWS : PANEL_MAX_ROWS / 2;
  endfunction

  // Pixels off the active panel are dropped; both bounds must hold.
  function automatic void plot_dot(int unsigned px, int unsigned py, bit on);
    int unsigned addr;
    if (px >= PANEL_COLUMNS || py >= rows_now()) return;
    addr = (py / 8) * PANEL_COLUMNS + px;
    pixel_bytes[addr][py % 8] = on;
  endfunction

  function automatic void fill_area(int unsigned px, int unsigned py,
                                    int unsigned w, int unsigned h);
    int unsigned xe, ye;
    xe = px + w;
    ye = py + h;
    if (xe > PANEL_COLUMNS) xe = PANEL_COLUMNS;
    if (ye > rows_now()) ye = rows_now();
    for (int unsigned i = px; i < xe; i++)
      for (int unsigned j = py; j < ye; j++) plot_dot(i, j, 1'b1);
  endfunction

  // Leading image pixels, bit 7 first, both set and clear; counts above 8 saturate.
  function automatic void stamp_strip(int unsigned px, int unsigned py,
                                      logic [7:0] img, int unsigned n);
    if (n > 8) n = 8;
    for (int unsigned i = 0; i < n; i++) plot_dot(px + i, py, img[7 - i]);
  endfunction

  function automatic reply_t predict_word();
    reply_t r;
    r = '0;
    case (op)
      OP_CLEAR: wipe_store();
      OP_PIXEL: plot_dot(32'(x), 32'(y), pixel_value);
      OP_RECT:  fill_area(32'(x), 32'(y), 32'(rect_width), 32'(rect_height));
      OP_BLIT:  stamp_strip(32'(x), 32'(y), image_byte, 32'(valid_bits));
      OP_READ: begin
        r.was_rd = 1'b1;
        if (read_address < STORE_DEPTH) r.data = pixel_bytes[read_address];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      wipe_store();
      tall = 1'b1;
      replies.delete();
    end else begin
      // Results leave before the new command enters, so the oldest one is compared.
      if (pop && !empty) begin
        if (replies.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result word read_data=%h was_read=%b",
                     $realtime, read_data, was_read);
        end else begin
          want = replies.pop_front();
          if (want.data !== read_data || want.was_rd !== was_read) begin
            errors++;
            if (errors <= 10)
              $display("%0t: result mismatch: expected read_data=%h was_read=%b, got read_data=%h was_read=%b",
                       $realtime, want.data, want.was_rd, read_data, was_read);
          end
        end
      end
      if (push && !full) replies.push_back(predict_word());
      if (cfg_valid && cfg_ready) tall = cfg_data;
    end
    outstanding <= replies.size();
  end

endmodule

### bench/page_framebuffer_draw_engine_tb.sv
// Stimulus and verdict for the page framebuffer draw engine, with its checker alongside.
`timescale 1ns / 100ps
module page_framebuffer_draw_engine_tb;
  import fbde_pkg::*;

  // Op codes 5 to 7 are unused; the engine must answer them with a plain zero word.
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  // Number of random phases; they alternate between the short and the tall panel.
  localparam int PHASES     = 5;
  localparam int PHASE_WORDS = 90;

  typedef struct {
    logic [2:0] op;
    logic [7:0] x;
    logic [7:0] y;
    logic       pv;
    logic [7:0] w;
    logic [7:0] h;
    logic [7:0] img;
    logic [3:0] nb;
    logic [9:0] ra;
  } cmd_word_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [2:0] op;
  logic [7:0] x;
  logic [7:0] y;
  logic       pixel_value;
  logic [7:0] rect_width;
  logic [7:0] rect_height;
  logic [7:0] image_byte;
  logic [3:0] valid_bits;
  logic [9:0] read_address;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] read_data;
  logic       was_read;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  int         outstanding;
  int         errors;

  // While calm is set neither side inserts idle cycles.
  bit         calm = 1'b0;

  // Position of the most recent draw, so that many reads land where pixels changed.
  logic [7:0] last_x = 8'd0;
  logic [7:0] last_y = 8'd0;

  page_framebuffer_draw_engine DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .x            (x),
    .y            (y),
    .pixel_value  (pixel_value),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .image_byte   (image_byte),
    .valid_bits   (valid_bits),
    .read_address (read_address),
    .empty        (empty),
    .pop          (pop),
    .read_data    (read_data),
    .was_read     (was_read),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  fb_draw_checker draw_check (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .x            (x),
    .y            (y),
    .pixel_value  (pixel_value),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .image_byte   (image_byte),
    .valid_bits   (valid_bits),
    .read_address (read_address),
    .empty        (empty),
    .pop          (pop),
    .read_data    (read_data),
    .was_read     (was_read),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .errors       (errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The result side pops at random with odds of about 81 in 100, and always while calm.
  always @(posedge clk) pop <= !rst && (calm || $urandom_range(0, 99) >= 19);

  // Every field is random, so fields that an op ignores still toggle.
  function automatic cmd_word_t any_word();
    cmd_word_t c;
    c.op  = 3'($urandom_range(0, 7));
    c.x   = 8'($urandom_range(0, 255));
    c.y   = 8'($urandom_range(0, 255));
    c.pv  = 1'($urandom_range(0, 1));
    c.w   = 8'($urandom_range(0, 255));
    c.h   = 8'($urandom_range(0, 255));
    c.img = 8'($urandom_range(0, 255));
    c.nb  = 4'($urandom_range(0, 15));
    c.ra  = 10'($urandom_range(0, 1023));
    return c;
  endfunction

  function automatic cmd_word_t bare_word(logic [2:0] code);
    cmd_word_t c;
    c = any_word();
    c.op = code;
    return c;
  endfunction

  function automatic cmd_word_t dot_word(logic [7:0] px, logic [7:0] py, logic v);
    cmd_word_t c;
    c = bare_word(OP_PIXEL);
    c.x  = px;
    c.y  = py;
    c.pv = v;
    return c;
  endfunction

  function automatic cmd_word_t box_word(logic [7:0] px, logic [7:0] py,
                                         logic [7:0] w, logic [7:0] h);
    cmd_word_t c;
    c = bare_word(OP_RECT);
    c.x = px;
    c.y = py;
    c.w = w;
    c.h = h;
    return c;
  endfunction

  function automatic cmd_word_t strip_word(logic [7:0] px, logic [7:0] py,
                                           logic [7:0] img, logic [3:0] n);
    cmd_word_t c;
    c = bare_word(OP_BLIT);
    c.x   = px;
    c.y   = py;
    c.img = img;
    c.nb  = n;
    return c;
  endfunction

  function automatic cmd_word_t peek_word(logic [9:0] addr);
    cmd_word_t c;
    c = bare_word(OP_READ);
    c.ra = addr;
    return c;
  endfunction

  // Coordinates stay near the panel most of the time and cover the whole byte otherwise.
  function automatic logic [7:0] pick_x();
    return 8'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 135)
                                           : $urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_y();
    return 8'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 70)
                                           : $urandom_range(0, 255));
  endfunction

  function automatic logic [3:0] pick_count();
    return 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                          : $urandom_range(1, 8));
  endfunction

  // Presents one command word and returns at the edge that accepts it. Push stays
  // high afterwards so that back-to-back words need no second assignment in a step.
  task automatic send_word(input cmd_word_t c);
    // Each cycle ahead of the word is idle with the same odds, so about 19 in 100 are.
    while (!calm && $urandom_range(0, 99) < 19) begin
      push <= 1'b0;
      @(posedge clk);
    end
    op           <= c.op;
    x            <= c.x;
    y            <= c.y;
    pixel_value  <= c.pv;
    rect_width   <= c.w;
    rect_height  <= c.h;
    image_byte   <= c.img;
    valid_bits   <= c.nb;
    read_address <= c.ra;
    push         <= 1'b1;
    do @(posedge clk); while (full);
    if (c.op != OP_READ) begin
      last_x = c.x;
      last_y = c.y;
    end
  endtask

  // The panel height only changes once push is low and every result word is back,
  // with a wait on each side of that check.
  task automatic write_panel(input bit v);
    push <= 1'b0;
    repeat (4) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    cmd_word_t c;
    int        sel;

    rst          = 1'b1;
    push         = 1'b0;
    op           = OP_CLEAR;
    x            = 8'd0;
    y            = 8'd0;
    pixel_value  = 1'b0;
    rect_width   = 8'd0;
    rect_height  = 8'd0;
    image_byte   = 8'd0;
    valid_bits   = 4'd0;
    read_address = 10'd0;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // The first write lands during the clearing sweep after reset, which does not
    // depend on the panel height.
    write_panel(1'b1);

    // Directed words on the tall panel: corners, both bounds, empty and clipped
    // rectangles, blits with no, full and saturated counts, clear, unused codes.
    send_word(peek_word(10'd0));
    send_word(dot_word(8'd0, 8'd0, 1'b1));
    send_word(dot_word(8'd127, 8'd63, 1'b1));
    send_word(dot_word(8'd128, 8'd5, 1'b1));
    send_word(dot_word(8'd5, 8'd64, 1'b1));
    send_word(dot_word(8'd255, 8'd255, 1'b1));
    send_word(peek_word(10'd0));
    send_word(peek_word(10'd1023));
    send_word(dot_word(8'd0, 8'd0, 1'b0));
    send_word(peek_word(10'd0));
    send_word(box_word(8'd10, 8'd3, 8'd0, 8'd5));
    send_word(box_word(8'd10, 8'd3, 8'd5, 8'd0));
    send_word(box_word(8'd120, 8'd60, 8'd255, 8'd255));
    send_word(peek_word(10'd1016));
    send_word(strip_word(8'd0, 8'd9, 8'hA5, 4'd8));
    send_word(strip_word(8'd124, 8'd17, 8'hFF, 4'd15));
    send_word(strip_word(8'd2, 8'd9, 8'h00, 4'd0));
    send_word(peek_word(10'd130));
    send_word(peek_word(10'd383));
    send_word(box_word(8'd0, 8'd0, 8'd255, 8'd255));
    send_word(peek_word(10'd1023));
    send_word(bare_word(OP_CLEAR));
    send_word(peek_word(10'd1023));
    send_word(bare_word(OP_UNUSED_FIRST));
    send_word(bare_word(OP_UNUSED_LAST));

    // Random phases alternate between the short and the tall panel. The middle
    // phase runs with no idling on either side.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_panel(1'(ph % 2));
      calm <= (ph == 2);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
          c = dot_word(pick_x(), pick_y(), 1'($urandom_range(0, 1)));
        end else if (sel < 34) begin
          // Large rectangles cost a pass over most of the store, so they are rare.
          if ($urandom_range(0, 19) == 0)
            c = box_word(pick_x(), pick_y(), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
          else
            c = box_word(pick_x(), pick_y(), 8'($urandom_range(0, 12)),
                         8'($urandom_range(0, 12)));
        end else if (sel < 54) begin
          c = strip_word(pick_x(), pick_y(), 8'($urandom_range(0, 255)), pick_count());
        end else if (sel < 90) begin
          // Most reads look at the bytes that the last draw could have touched.
          if ($urandom_range(0, 3) == 0)
            c = peek_word(10'($urandom_range(0, 1023)));
          else
            c = peek_word({last_y[5:3], 7'(last_x + $urandom_range(0, 7))});
        end else if (sel < 92) begin
          c = bare_word(OP_CLEAR);
        end else begin
          c = any_word();
        end
        send_word(c);
      end
    end

    // Drain, then leave room for a late clear before the verdict.
    push <= 1'b0;
    calm <= 1'b0;
    repeat (4) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
